### src/navigation_source_failover_arbiter_core_assert.svh
// Assertion macros for the navigation source failover arbiter.
// Used by the port checker; no other dependencies.
`ifndef NAVIGATION_SOURCE_FAILOVER_ARBITER_CORE_ASSERT_SVH
`define NAVIGATION_SOURCE_FAILOVER_ARBITER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define NSFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsfa check failed");
// Next-cycle implication checked outside reset.
`define NSFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsfa check failed");
`endif

### src/nsfa_pkg.sv
// Package for the navigation source failover arbiter: state, request and
// register codes, field widths and datapath command/status structs.
`timescale 1ns / 1ps
package nsfa_pkg;
  localparam int unsigned TimeW = 64;
  localparam int unsigned FracW = 17;
  localparam logic [FracW-1:0] FracOne = 17'h10000;
  localparam logic [31:0] NoiseThresh = 32'd655;
  localparam int unsigned DivSteps = 16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0, ST_VISION = 3'd1, ST_TO_GPS = 3'd2,
    ST_GPS = 3'd3, ST_TO_VISION = 3'd4
  } arb_state_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0, REQ_GPS = 2'd1, REQ_VISION = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    REG_EV_TIMEOUT = 3'd0, REG_BLEND_TIME = 3'd1, REG_RECOVERY = 3'd2,
    REG_EV_BITS = 3'd3, REG_GPS_BITS = 3'd4, REG_NOISE_CEIL = 3'd5,
    REG_NOISE_BASE_INIT = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    CT_IDLE, CT_DECIDE, CT_LOAD, CT_DIVIDE, CT_MULT, CT_FINISH, CT_OUT
  } ctl_state_t;

  typedef struct packed {
    logic       capture;   // register input item
    logic       update;    // apply state update (timers, baseline, arb state)
    logic       div_start; // load divider
    logic       div_step;  // one restoring step
    logic       mult;      // register ramp product
    logic       finish;    // form result payload
  } dp_cmd_t;

  typedef struct packed {
    logic       div_done;
  } dp_sts_t;
endpackage

### src/nsfa_if.sv
// Valid/ready channel interfaces for the arbiter: input item, result item,
// configuration write. Depends on nothing.
`timescale 1ns / 1ps
interface nsfa_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        command;
  logic        enable_req;
  logic [1:0]  switch_req;
  logic [63:0] now_us;
  logic        vis_alive;
  logic        vis_fused;
  logic [7:0]  ev_ctrl_now;
  logic [7:0]  gps_ctrl_now;
  logic [31:0] noise_now;
  logic        noise_mode_now;
  modport source (output valid, command, enable_req, switch_req, now_us, vis_alive,
                  vis_fused, ev_ctrl_now, gps_ctrl_now, noise_now, noise_mode_now,
                  input ready);
  modport sink (input valid, command, enable_req, switch_req, now_us, vis_alive,
                vis_fused, ev_ctrl_now, gps_ctrl_now, noise_now, noise_mode_now,
                output ready);
endinterface

interface nsfa_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  state_code;
  logic [7:0]  ev_ctrl_next;
  logic        ev_ctrl_write;
  logic [7:0]  gps_ctrl_next;
  logic        gps_ctrl_write;
  logic [31:0] noise_next;
  logic        noise_write;
  logic        mode_next;
  logic        mode_write;
  logic [16:0] blend_level;
  logic        command_ack;
  modport source (output valid, state_code, ev_ctrl_next, ev_ctrl_write, gps_ctrl_next,
                  gps_ctrl_write, noise_next, noise_write, mode_next, mode_write,
                  blend_level, command_ack, input ready);
  modport sink (input valid, state_code, ev_ctrl_next, ev_ctrl_write, gps_ctrl_next,
                gps_ctrl_write, noise_next, noise_write, mode_next, mode_write,
                blend_level, command_ack, output ready);
endinterface

interface nsfa_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/navigation_source_failover_arbiter_core.sv
// Top level of the navigation source failover arbiter core.
// Joins nsfa_ctrl and nsfa_dp; uses nsfa_pkg and the nsfa interfaces.
//
// Usage:
//  - in: one item per tick or command; taken when in.valid and in.ready.
//  - out: exactly one result item per input item, in order.
//  - cfg: register writes (index 0..6), always ready; write only while idle.
// Sequence: after the accepting edge the item is captured, then come the
// state update, divider load, 16 restoring steps plus the done check, ramp
// multiply and payload register, and out.valid rises. The next item is
// accepted only after the result has been taken, so the block takes no new
// item while one is in flight; the bit-serial divider sets most of the time.
// Reset: synchronous, active low. State goes idle, no pending switch,
// timers zero, configuration to defaults; the noise baseline loads the
// default of noise_baseline_initial, and later writes of that register
// leave the baseline alone.
// Stall: when out.ready is low the result holds in the output register and
// in.ready stays low until it is taken.
`timescale 1ns / 1ps
module navigation_source_failover_arbiter_core (
  input logic        clk,
  input logic        rst_n,
  nsfa_in_if.sink    in_ch,
  nsfa_out_if.source out_ch,
  nsfa_cfg_if.sink   cfg_ch
);
  import nsfa_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    busy;
  logic    out_valid;

  // accept only when the sequencer is free
  assign in_ch.ready = !busy;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  nsfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_ch.valid && !busy),
    .out_fire  (out_ch.ready && out_valid),
    .sts       (dp_sts),
    .cmd       (dp_cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  nsfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_wdata (cfg_ch.data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );
endmodule

### src/nsfa_ctrl.sv
// Sequencer for the arbiter: walks each item through decide, divider load,
// divide, multiply, finish and output steps. Uses nsfa_pkg.
`timescale 1ns / 1ps
module nsfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  nsfa_pkg::dp_sts_t sts,
  output nsfa_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import nsfa_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      CT_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt = CT_DECIDE;
        end
      end
      CT_DECIDE: begin
        cmd.update = 1'b1;
        state_nxt = CT_LOAD;
      end
      CT_LOAD: begin
        // load the divider from the updated blend start
        cmd.div_start = 1'b1;
        state_nxt = CT_DIVIDE;
      end
      CT_DIVIDE: begin
        // step until the quotient is complete
        if (sts.div_done) begin
          state_nxt = CT_MULT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      CT_MULT: begin
        cmd.mult = 1'b1;
        state_nxt = CT_FINISH;
      end
      CT_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = CT_OUT;
      end
      CT_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_nxt = CT_IDLE;
        end
      end
      default: state_nxt = CT_IDLE;
    endcase
  end
endmodule

### src/nsfa_dp.sv
// Datapath of the arbiter: configuration registers, arbiter state, timers,
// blend-fraction divider and noise ramp. Uses nsfa_pkg.
`timescale 1ns / 1ps
module nsfa_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  nsfa_pkg::dp_cmd_t cmd,
  output nsfa_pkg::dp_sts_t sts,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata,
  nsfa_in_if.sink           in_ch,
  nsfa_out_if.source        out_ch
);
  import nsfa_pkg::*;

  // configuration
  logic [31:0] ev_timeout_r, blend_time_r, recovery_r, noise_ceil_r;
  logic [7:0]  ev_bits_r, gnss_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_timeout_r <= 32'd1000000;
      blend_time_r <= 32'd2000000;
      recovery_r   <= 32'd3000000;
      ev_bits_r    <= 8'd1;
      gnss_mask_r  <= 8'd1;
      noise_ceil_r <= 32'd655360;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_EV_TIMEOUT:      ev_timeout_r <= cfg_wdata;
        REG_BLEND_TIME:      blend_time_r <= cfg_wdata;
        REG_RECOVERY:        recovery_r   <= cfg_wdata;
        REG_EV_BITS:         ev_bits_r    <= cfg_wdata[7:0];
        REG_GPS_BITS:        gnss_mask_r  <= cfg_wdata[7:0];
        REG_NOISE_CEIL:      noise_ceil_r <= cfg_wdata;
        // the baseline takes its initial value at reset only
        REG_NOISE_BASE_INIT: ;
        default: ;
      endcase
    end
  end

  // captured item
  logic        cmd_r, en_r, alive_r, fusing_r, md_r;
  logic [1:0]  sw_r;
  logic [63:0] now_r;
  logic [7:0]  evc_r, gpc_r;
  logic [31:0] nz_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_ch.command;
      en_r     <= in_ch.enable_req;
      sw_r     <= in_ch.switch_req;
      now_r    <= in_ch.now_us;
      alive_r  <= in_ch.vis_alive;
      fusing_r <= in_ch.vis_fused;
      evc_r    <= in_ch.ev_ctrl_now;
      gpc_r    <= in_ch.gps_ctrl_now;
      nz_r     <= in_ch.noise_now;
      md_r     <= in_ch.noise_mode_now;
    end
  end

  // arbiter state and timers
  arb_state_t  arb_r, arb_nxt;
  req_t        pend_r, pend_nxt;
  logic [63:0] lost_r, lost_nxt, good_r, good_nxt, bstart_r, bstart_nxt;
  logic [31:0] base_r, base_nxt;
  logic [63:0] lost_pre, good_pre;
  logic [63:0] since_lost, since_good, since_blend;

  // a zero timer is unset: arm it with the current time
  assign lost_pre    = (lost_r == '0) ? now_r : lost_r;
  assign good_pre    = (good_r == '0) ? now_r : good_r;
  assign since_lost  = now_r - lost_pre;
  assign since_good  = now_r - good_pre;
  assign since_blend = now_r - bstart_r;

  always_comb begin
    arb_nxt = arb_r;
    pend_nxt = pend_r;
    lost_nxt = lost_r;
    good_nxt = good_r;
    bstart_nxt = bstart_r;
    base_nxt = base_r;
    if (cmd_r) begin
      if (en_r) begin
        if (arb_r == ST_IDLE) begin
          arb_nxt = ST_VISION;
          lost_nxt = '0;
        end
        if (sw_r[1]) begin
          pend_nxt = REQ_VISION;
        end else if (sw_r[0]) begin
          pend_nxt = REQ_GPS;
        end
      end else if (arb_r != ST_IDLE) begin
        arb_nxt = ST_IDLE;
        pend_nxt = REQ_NONE;
      end
    end else begin
      case (arb_r)
        ST_IDLE: ;
        ST_VISION: begin
          if (pend_r == REQ_GPS) begin
            base_nxt = nz_r;
            arb_nxt = ST_TO_GPS;
            bstart_nxt = now_r;
            pend_nxt = REQ_NONE;
          end else if (fusing_r) begin
            lost_nxt = '0;
          end else begin
            lost_nxt = lost_pre;
            if (since_lost >= {32'd0, ev_timeout_r}) begin
              base_nxt = nz_r;
              arb_nxt = ST_TO_GPS;
              bstart_nxt = now_r;
            end
          end
        end
        ST_GPS: begin
          if (pend_r == REQ_VISION) begin
            good_nxt = now_r;
            arb_nxt = ST_TO_VISION;
            bstart_nxt = now_r;
            pend_nxt = REQ_NONE;
          end else if (alive_r) begin
            good_nxt = good_pre;
            if (since_good >= {32'd0, recovery_r}) begin
              arb_nxt = ST_TO_VISION;
              bstart_nxt = now_r;
            end
          end else begin
            good_nxt = '0;
          end
        end
        ST_TO_GPS: begin
          if (fusing_r) begin
            arb_nxt = ST_VISION;
            lost_nxt = '0;
          end else if (since_blend >= {32'd0, blend_time_r}) begin
            arb_nxt = ST_GPS;
            good_nxt = '0;
          end
        end
        ST_TO_VISION: begin
          if (!alive_r) begin
            arb_nxt = ST_GPS;
            good_nxt = '0;
          end else if (since_blend >= {32'd0, blend_time_r}) begin
            arb_nxt = ST_VISION;
            lost_nxt = '0;
          end
        end
        default: arb_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arb_r <= ST_IDLE;
      pend_r <= REQ_NONE;
      lost_r <= '0;
      good_r <= '0;
      bstart_r <= '0;
      base_r <= 32'd6554;
    end else if (cmd.update) begin
      arb_r <= arb_nxt;
      pend_r <= pend_nxt;
      lost_r <= lost_nxt;
      good_r <= good_nxt;
      bstart_r <= bstart_nxt;
      base_r <= base_nxt;
    end
  end

  // blend fraction: restoring divide of elapsed*65536 by blend time;
  // the quotient is used only when elapsed is below the blend time, so it fits the remainder
  logic [31:0] rem_r;
  logic [15:0] q_r;
  logic [4:0]  cnt_r;
  logic        full_r;
  logic [33:0] trial;

  assign trial = {1'b0, rem_r, 1'b0} - {2'd0, blend_time_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      full_r <= (blend_time_r == '0) || (since_blend >= {32'd0, blend_time_r});
      rem_r <= since_blend[31:0];
      q_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[33]) begin
        rem_r <= trial[31:0];
        q_r <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], 1'b0};
        q_r <= {q_r[14:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end
  assign sts.div_done = (cnt_r == 5'(DivSteps));

  logic [FracW-1:0] frac;
  assign frac = full_r ? FracOne : {1'b0, q_r};

  // noise ramp
  logic [31:0] ra, rb, rdiff;
  logic        rup;
  logic [48:0] prod_r;
  logic [31:0] ra_r;
  logic        rup_r;
  assign ra = (arb_r == ST_TO_GPS) ? base_r : noise_ceil_r;
  assign rb = (arb_r == ST_TO_GPS) ? noise_ceil_r : base_r;
  assign rup = (rb >= ra);
  assign rdiff = rup ? rb - ra : ra - rb;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_r <= {17'd0, rdiff} * {32'd0, frac} + 49'd32768;
      ra_r <= ra;
      rup_r <= rup;
    end
  end

  logic [31:0] ramp_v;
  assign ramp_v = rup_r ? ra_r + prod_r[47:16] : ra_r - prod_r[47:16];

  // result payload
  logic [7:0]  ev_n, gps_n;
  logic [31:0] nz_n, nd;
  logic        md_n, active, blend;
  always_comb begin
    ev_n = evc_r;
    gps_n = gpc_r;
    nz_n = nz_r;
    md_n = md_r;
    blend = 1'b0;
    active = 1'b0;
    if (!cmd_r) begin
      case (arb_r)
        ST_VISION: begin
          ev_n = evc_r | ev_bits_r;
          gps_n = gpc_r & ~gnss_mask_r;
          nz_n = base_r;
          md_n = 1'b0;
          active = 1'b1;
        end
        ST_TO_GPS, ST_TO_VISION: begin
          ev_n = evc_r | ev_bits_r;
          gps_n = gpc_r | gnss_mask_r;
          nz_n = ramp_v;
          md_n = 1'b1;
          active = 1'b1;
          blend = 1'b1;
        end
        ST_GPS: begin
          ev_n = evc_r & ~ev_bits_r;
          gps_n = gpc_r | gnss_mask_r;
        end
        default: ;
      endcase
    end
    nd = (nz_r > nz_n) ? nz_r - nz_n : nz_n - nz_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch.state_code <= arb_r;
      out_ch.ev_ctrl_next <= ev_n;
      out_ch.ev_ctrl_write <= (ev_n != evc_r);
      out_ch.gps_ctrl_next <= gps_n;
      out_ch.gps_ctrl_write <= (gps_n != gpc_r);
      out_ch.noise_next <= nz_n;
      out_ch.noise_write <= active && (nd > NoiseThresh);
      out_ch.mode_next <= md_n;
      out_ch.mode_write <= active && (md_n != md_r);
      out_ch.blend_level <= (blend && blend_time_r != '0) ? frac : '0;
      out_ch.command_ack <= cmd_r;
    end
  end
endmodule

### src/nsfa_checker.sv
// Port-level checker for the arbiter core, bound to the top level.
// Uses the assertion macro header and nsfa_pkg.
`timescale 1ns / 1ps
`include "navigation_source_failover_arbiter_core_assert.svh"
module nsfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  state_code,
  input logic [16:0] blend_level,
  input logic        command_ack
);
  import nsfa_pkg::*;

  `NSFA_ASSERT_IMPL(a_no_accept_while_result, out_valid, !in_ready)
  `NSFA_ASSERT_NEXT(a_accept_clears_ready, in_valid && in_ready, !in_ready)
  `NSFA_ASSERT_IMPL(a_state_range, out_valid, state_code <= ST_TO_VISION)
  `NSFA_ASSERT_IMPL(a_progress_only_blend, out_valid && blend_level != 17'd0, !command_ack && (state_code == ST_TO_GPS || state_code == ST_TO_VISION))
  `NSFA_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid)
endmodule

bind navigation_source_failover_arbiter_core nsfa_checker u_nsfa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .state_code  (out_ch.state_code),
  .blend_level (out_ch.blend_level),
  .command_ack (out_ch.command_ack)
);

### tb/tb.sv
// Self-checking bench for navigation_source_failover_arbiter_core.
// Depends on nsfa_pkg and the nsfa channel interfaces; predicts every result
// item in-bench and checks it field by field against the block's output.
`timescale 1ns / 1ps
module tb;
  import nsfa_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 30;

  typedef struct {
    logic        cmd;
    logic        en;
    logic [1:0]  sw;
    logic [63:0] now;
    logic        alive;
    logic        fusing;
    logic [7:0]  evc;
    logic [7:0]  gpc;
    logic [31:0] nz;
    logic        md;
  } nav_item_t;

  typedef struct {
    logic [2:0]  st;
    logic [7:0]  ev_n;
    logic        ev_w;
    logic [7:0]  gps_n;
    logic        gps_w;
    logic [31:0] nz_n;
    logic        nz_w;
    logic        md_n;
    logic        md_w;
    logic [16:0] prog;
    logic        ack;
  } nav_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsfa_in_if  in_if (clk);
  nsfa_out_if out_if (clk);
  nsfa_cfg_if cfg_if (clk);

  navigation_source_failover_arbiter_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow configuration, held at the reset defaults until written.
  logic [31:0] ev_timeout = 32'd1000000;
  logic [31:0] blend_time = 32'd2000000;
  logic [31:0] recovery   = 32'd3000000;
  logic [7:0]  ev_bits    = 8'd1;
  logic [7:0]  gnss_mask  = 8'd1;
  logic [31:0] noise_ceil = 32'd655360;

  // Shadow arbiter state.
  arb_state_t  arb_st    = ST_IDLE;
  req_t        pend      = REQ_NONE;
  logic [63:0] lost_t    = '0;
  logic [63:0] good_t    = '0;
  logic [63:0] bstart_t  = '0;
  logic [31:0] baseline  = 32'd6554;

  nav_result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;
  logic [63:0] t_now = 64'd1000;
  int unsigned step_shift = 0;
  int unsigned step_max = 1000;
  bit          vision_ok = 1'b1;

  // Blend fraction in Q1.16, capped at one.
  function automatic logic [31:0] blend_frac(input logic [63:0] now);
    logic [63:0] el;
    el = now - bstart_t;
    if (blend_time == 0 || el >= {32'd0, blend_time}) return 32'h10000;
    return 32'((el << 16) / {32'd0, blend_time});
  endfunction

  // Linear ramp from a toward b, with the step size rounded half up.
  function automatic logic [31:0] noise_ramp(input logic [31:0] a, b, input logic [31:0] frac);
    logic [63:0] d;
    if (b >= a) begin
      d = ({32'd0, b - a} * frac + 64'd32768) >> 16;
      return 32'({32'd0, a} + d);
    end
    d = ({32'd0, a - b} * frac + 64'd32768) >> 16;
    return 32'({32'd0, a} - d);
  endfunction

  // Advance the shadow arbiter by one item and form the result it yields.
  function automatic nav_result_t arbitrate(input nav_item_t it);
    nav_result_t r;
    logic [31:0] d;
    r.ev_n = it.evc;
    r.gps_n = it.gpc;
    r.nz_n = it.nz;
    r.md_n = it.md;
    r.nz_w = 1'b0;
    r.md_w = 1'b0;
    r.prog = '0;
    if (it.cmd) begin
      if (it.en) begin
        if (arb_st == ST_IDLE) begin
          arb_st = ST_VISION;
          lost_t = '0;
        end
        // Switch request three counts as force vision.
        if (it.sw >= 2) pend = REQ_VISION;
        else if (it.sw == 1) pend = REQ_GPS;
      end else if (arb_st != ST_IDLE) begin
        arb_st = ST_IDLE;
        pend = REQ_NONE;
      end
    end else if (arb_st != ST_IDLE) begin
      case (arb_st)
        ST_VISION: begin
          if (pend == REQ_GPS) begin
            baseline = it.nz;
            arb_st = ST_TO_GPS;
            bstart_t = it.now;
            pend = REQ_NONE;
          end else if (it.fusing) begin
            lost_t = '0;
          end else begin
            if (lost_t == 0) lost_t = it.now;
            if (it.now - lost_t >= {32'd0, ev_timeout}) begin
              baseline = it.nz;
              arb_st = ST_TO_GPS;
              bstart_t = it.now;
            end
          end
        end
        ST_GPS: begin
          if (pend == REQ_VISION) begin
            good_t = it.now;
            arb_st = ST_TO_VISION;
            bstart_t = it.now;
            pend = REQ_NONE;
          end else if (it.alive) begin
            if (good_t == 0) good_t = it.now;
            if (it.now - good_t >= {32'd0, recovery}) begin
              arb_st = ST_TO_VISION;
              bstart_t = it.now;
            end
          end else begin
            good_t = '0;
          end
        end
        ST_TO_GPS: begin
          if (it.fusing) begin
            arb_st = ST_VISION;
            lost_t = '0;
          end else if (it.now - bstart_t >= {32'd0, blend_time}) begin
            arb_st = ST_GPS;
            good_t = '0;
          end
        end
        ST_TO_VISION: begin
          if (!it.alive) begin
            arb_st = ST_GPS;
            good_t = '0;
          end else if (it.now - bstart_t >= {32'd0, blend_time}) begin
            arb_st = ST_VISION;
            lost_t = '0;
          end
        end
        default: arb_st = ST_IDLE;
      endcase

      case (arb_st)
        ST_VISION: begin
          r.ev_n = it.evc | ev_bits;
          r.gps_n = it.gpc & ~gnss_mask;
          r.nz_n = baseline;
          r.md_n = 1'b0;
        end
        ST_TO_GPS: begin
          r.ev_n = it.evc | ev_bits;
          r.gps_n = it.gpc | gnss_mask;
          r.nz_n = noise_ramp(baseline, noise_ceil, blend_frac(it.now));
          r.md_n = 1'b1;
        end
        ST_TO_VISION: begin
          r.ev_n = it.evc | ev_bits;
          r.gps_n = it.gpc | gnss_mask;
          r.nz_n = noise_ramp(noise_ceil, baseline, blend_frac(it.now));
          r.md_n = 1'b1;
        end
        ST_GPS: begin
          r.ev_n = it.evc & ~ev_bits;
          r.gps_n = it.gpc | gnss_mask;
        end
        default: ;
      endcase
      if (arb_st == ST_VISION || arb_st == ST_TO_GPS || arb_st == ST_TO_VISION) begin
        d = (it.nz > r.nz_n) ? it.nz - r.nz_n : r.nz_n - it.nz;
        r.nz_w = d > NoiseThresh;
        r.md_w = it.md != r.md_n;
      end
    end
    if (!it.cmd && (arb_st == ST_TO_GPS || arb_st == ST_TO_VISION) && blend_time > 0)
      r.prog = 17'(blend_frac(it.now));
    r.st = arb_st;
    r.ev_w = r.ev_n != it.evc;
    r.gps_w = r.gps_n != it.gpc;
    r.ack = it.cmd;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got, exp_v);
    $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $realtime, results_seen, field,
             got, exp_v);
    errors++;
  endtask

  // Check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    nav_result_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 64'd0, 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_if.state_code !== w.st)
          report_mismatch("state_code", 64'(out_if.state_code), 64'(w.st));
        if (out_if.ev_ctrl_next !== w.ev_n)
          report_mismatch("ev_ctrl_next", 64'(out_if.ev_ctrl_next), 64'(w.ev_n));
        if (out_if.ev_ctrl_write !== w.ev_w)
          report_mismatch("ev_ctrl_write", 64'(out_if.ev_ctrl_write), 64'(w.ev_w));
        if (out_if.gps_ctrl_next !== w.gps_n)
          report_mismatch("gps_ctrl_next", 64'(out_if.gps_ctrl_next), 64'(w.gps_n));
        if (out_if.gps_ctrl_write !== w.gps_w)
          report_mismatch("gps_ctrl_write", 64'(out_if.gps_ctrl_write), 64'(w.gps_w));
        if (out_if.noise_next !== w.nz_n)
          report_mismatch("noise_next", 64'(out_if.noise_next), 64'(w.nz_n));
        if (out_if.noise_write !== w.nz_w)
          report_mismatch("noise_write", 64'(out_if.noise_write), 64'(w.nz_w));
        if (out_if.mode_next !== w.md_n)
          report_mismatch("mode_next", 64'(out_if.mode_next), 64'(w.md_n));
        if (out_if.mode_write !== w.md_w)
          report_mismatch("mode_write", 64'(out_if.mode_write), 64'(w.md_w));
        if (out_if.blend_level !== w.prog)
          report_mismatch("blend_level", 64'(out_if.blend_level), 64'(w.prog));
        if (out_if.command_ack !== w.ack)
          report_mismatch("command_ack", 64'(out_if.command_ack), 64'(w.ack));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d items still expected", cycles,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: stall in random bursts while idling is on.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_if.ready = 1'b1;
    end
  end

  // Drive one item; entered and left at a falling edge.
  task automatic send_item(input nav_item_t it);
    if (idle_en && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 19)) @(negedge clk);
    in_if.command = it.cmd;
    in_if.enable_req = it.en;
    in_if.switch_req = it.sw;
    in_if.now_us = it.now;
    in_if.vis_alive = it.alive;
    in_if.vis_fused = it.fusing;
    in_if.ev_ctrl_now = it.evc;
    in_if.gps_ctrl_now = it.gpc;
    in_if.noise_now = it.nz;
    in_if.noise_mode_now = it.md;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(arbitrate(it));
    items_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // Random control words and noise around the usual Q16.16 range.
  function automatic nav_item_t rand_item();
    nav_item_t it;
    it.cmd = 1'b0;
    it.en = 1'($urandom_range(0, 1));
    it.sw = 2'($urandom_range(0, 3));
    it.now = t_now;
    it.alive = 1'($urandom_range(0, 1));
    it.fusing = 1'($urandom_range(0, 1));
    it.evc = 8'($urandom_range(0, 255));
    it.gpc = 8'($urandom_range(0, 255));
    it.nz = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 800000);
    it.md = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_cmd(input logic en, input logic [1:0] sw);
    nav_item_t it;
    it = rand_item();
    it.cmd = 1'b1;
    it.en = en;
    it.sw = sw;
    send_item(it);
  endtask

  task automatic send_tick(input logic [63:0] step, input logic alive, fusing);
    nav_item_t it;
    t_now += step;
    it = rand_item();
    it.alive = alive;
    it.fusing = fusing;
    send_item(it);
  endtask

  // Hold off until every result is back and the block has settled.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_if.index = idx;
    cfg_if.data = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_EV_TIMEOUT:      ev_timeout = val;
      REG_BLEND_TIME:      blend_time = val;
      REG_RECOVERY:        recovery = val;
      REG_EV_BITS:         ev_bits = val[7:0];
      REG_GPS_BITS:        gnss_mask = val[7:0];
      REG_NOISE_CEIL:      noise_ceil = val;
      // The baseline is loaded only at reset, so later writes leave it alone.
      REG_NOISE_BASE_INIT: ;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(input logic [31:0] tmo, bt, rec, input logic [7:0] evb, gpb,
                           input logic [31:0] ceil, init);
    wait_idle();
    write_reg(REG_EV_TIMEOUT, tmo);
    write_reg(REG_BLEND_TIME, bt);
    write_reg(REG_RECOVERY, rec);
    write_reg(REG_EV_BITS, {24'd0, evb});
    write_reg(REG_GPS_BITS, {24'd0, gpb});
    write_reg(REG_NOISE_CEIL, ceil);
    write_reg(REG_NOISE_BASE_INIT, init);
  endtask

  // Extremes of every field, every command form and the special cases:
  // idle ticks, switch request three, stale requests, timer wrap.
  task automatic test_directed();
    nav_item_t it;
    it = rand_item();
    it.now = 64'd0; it.evc = 8'h00; it.gpc = 8'hFF; it.nz = 32'd0; it.md = 1'b0;
    send_item(it);
    it.now = '1; it.evc = 8'hFF; it.gpc = 8'h00; it.nz = '1; it.md = 1'b1;
    send_item(it);
    send_cmd(1'b0, 2'd0);
    send_cmd(1'b1, 2'd3);
    send_tick(64'd500000, 1'b1, 1'b1);
    send_cmd(1'b1, 2'd1);
    send_tick(64'd100, 1'b1, 1'b0);
    send_tick(64'd1000000, 1'b1, 1'b0);
    send_tick(64'd1500000, 1'b0, 1'b0);
    send_cmd(1'b1, 2'd2);
    send_tick(64'd1000, 1'b1, 1'b0);
    send_tick(64'd600000, 1'b1, 1'b0);
    send_tick(64'd3000000, 1'b1, 1'b1);
    send_tick(64'd10, 1'b1, 1'b0);
    send_tick(64'd1500000, 1'b1, 1'b0);
    send_cmd(1'b1, 2'd0);
    // Drive the clock across the 64-bit wrap with the timers armed.
    t_now = 64'hFFFF_FFFF_FFF0_0000;
    send_tick(64'd0, 1'b1, 1'b0);
    send_tick(64'd1100000, 1'b1, 1'b0);
    send_tick(64'd900000, 1'b0, 1'b0);
    send_tick(64'd2500000, 1'b1, 1'b1);
    send_cmd(1'b0, 2'd1);
    send_tick(64'd5, 1'b1, 1'b1);
    send_cmd(1'b1, 2'd1);
    t_now = 64'd1000;
  endtask

  // Mostly well-formed health sequences with commands and noise mixed in.
  task automatic test_failover(input int unsigned n);
    nav_item_t it;
    int unsigned r;
    logic alive, fusing;
    send_cmd(1'b1, 2'd0);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) vision_ok = !vision_ok;
      if (r < 4) begin
        send_cmd(1'b1, 2'($urandom_range(0, 3)));
      end else if (r < 6) begin
        send_cmd(1'b0, 2'($urandom_range(0, 3)));
      end else if (r < 8) begin
        it = rand_item();
        it.now = {$urandom, $urandom};
        send_item(it);
      end else begin
        alive = vision_ok ? 1'b1 : ($urandom_range(0, 5) == 0);
        fusing = vision_ok ? ($urandom_range(0, 9) != 0) : 1'b0;
        send_tick(64'($urandom_range(0, step_max)) << step_shift, alive, fusing);
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.command = 1'b0;
    in_if.enable_req = 1'b0;
    in_if.switch_req = '0;
    in_if.now_us = '0;
    in_if.vis_alive = 1'b0;
    in_if.vis_fused = 1'b0;
    in_if.ev_ctrl_now = '0;
    in_if.gps_ctrl_now = '0;
    in_if.noise_now = '0;
    in_if.noise_mode_now = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_EV_TIMEOUT;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();

    step_shift = 0; step_max = 1200;
    configure(32'd1000, 32'd2000, 32'd3000, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), $urandom_range(0, 2000000), $urandom);
    test_failover(300);

    // Zero timers: every transition fires at once and blends are immediate.
    configure(32'd0, 32'd0, 32'd0, 8'h00, 8'h00, 32'd0, 32'd0);
    test_failover(150);

    step_shift = 23; step_max = 1000;
    configure('1, '1, '1, 8'hFF, 8'hFF, '1, '1);
    test_failover(150);

    step_shift = 0; step_max = 3000;
    configure($urandom_range(0, 5000), $urandom_range(1, 5000), $urandom_range(0, 5000),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom, $urandom);
    test_failover(300);

    // Final stretch at full rate on both sides.
    step_max = 1200;
    configure(32'd1000, 32'd2000, 32'd3000, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), $urandom_range(0, 2000000),
              $urandom_range(0, 100000));
    idle_en = 1'b0;
    test_failover(300);

    wait_idle();
    $display("Sent %0d items through five configurations, checked %0d results.", items_sent,
             results_seen);
    $display("Covered commands, failover, recovery, blends, timer wrap and zero/max settings.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
